// ----- sv/tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// touch point conditioner package
// Shared types, widths, register indexes and controller codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int COORD_W              = 10;
    localparam int AVG_W                = 14;
    localparam int FRAC_W               = 4;
    localparam int TIME_W               = 32;
    localparam int TIMEOUT_W            = 16;
    localparam int CFG_IDX_W            = 3;
    localparam int CFG_DATA_W           = 16;
    localparam int DEFAULT_FILTER_DEPTH = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT_MS = 3'd5;

    // reset values
    localparam logic [COORD_W-1:0]   RST_WINDOW_MIN    = 10'd0;
    localparam logic [COORD_W-1:0]   RST_WINDOW_MAX    = 10'd1023;
    localparam logic [COORD_W-1:0]   RST_DEADZONE      = 10'd5;
    localparam logic [TIMEOUT_W-1:0] RST_LOST_TIMEOUT  = 16'd1000;

    typedef struct packed {
        logic [COORD_W-1:0] x_raw;
        logic [COORD_W-1:0] y_raw;
        logic               pressed;
        logic [TIME_W-1:0]  time_ms;
    } tpc_in_t;

    typedef struct packed {
        logic [AVG_W-1:0] avg_x;
        logic [AVG_W-1:0] avg_y;
        logic             in_window;
        logic             go_home;
    } tpc_out_t;

    typedef struct packed {
        logic [COORD_W-1:0]   window_min_x;
        logic [COORD_W-1:0]   window_max_x;
        logic [COORD_W-1:0]   window_min_y;
        logic [COORD_W-1:0]   window_max_y;
        logic [COORD_W-1:0]   deadzone;
        logic [TIMEOUT_W-1:0] lost_timeout_ms;
    } tpc_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_BOUND,
        ST_CHECK,
        ST_DIVIDE,
        ST_FINISH
    } tpc_state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic bound;
        logic check;
        logic finish;
    } tpc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } tpc_status_t;

endpackage

// ----- sv/tpc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// tpc configuration registers
// Write-only register file for window bounds, deadzone and lost timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tpc_pkg::tpc_cfg_t                cfg
);

    tpc_pkg::tpc_cfg_t cfg_reg;
    tpc_pkg::tpc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tpc_pkg::REG_WINDOW_MIN_X:
                    cfg_next.window_min_x = cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::REG_WINDOW_MAX_X:
                    cfg_next.window_max_x = cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::REG_WINDOW_MIN_Y:
                    cfg_next.window_min_y = cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::REG_WINDOW_MAX_Y:
                    cfg_next.window_max_y = cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::REG_DEADZONE:
                    cfg_next.deadzone = cfg_data[tpc_pkg::COORD_W-1:0];
                tpc_pkg::REG_LOST_TIMEOUT_MS:
                    cfg_next.lost_timeout_ms = cfg_data[tpc_pkg::TIMEOUT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_min_x    <= tpc_pkg::RST_WINDOW_MIN;
            cfg_reg.window_max_x    <= tpc_pkg::RST_WINDOW_MAX;
            cfg_reg.window_min_y    <= tpc_pkg::RST_WINDOW_MIN;
            cfg_reg.window_max_y    <= tpc_pkg::RST_WINDOW_MAX;
            cfg_reg.deadzone        <= tpc_pkg::RST_DEADZONE;
            cfg_reg.lost_timeout_ms <= tpc_pkg::RST_LOST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/tpc_serial_div.sv -----
// ----------------------------------------------------------------------------
// tpc serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpc_serial_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [STEP_W-1:0]     step_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});
    assign done  = (step_reg == '0);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(DIVIDEND_W);
        end
        else if (!done)
        begin
            // shift the dividend out while quotient bits shift in
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign quotient = quo_reg;

endmodule

// ----- sv/tpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpc controller
// Sequences one item through update, bound, check, divide and finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tpc_pkg::tpc_status_t status,
    output tpc_pkg::tpc_cmd_t    cmd
);

    tpc_pkg::tpc_state_t state_reg;
    tpc_pkg::tpc_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tpc_pkg::ST_IDLE:
                if (in_valid)
                begin
                    state_next = tpc_pkg::ST_UPDATE;
                end
            tpc_pkg::ST_UPDATE:
                state_next = tpc_pkg::ST_BOUND;
            tpc_pkg::ST_BOUND:
                state_next = tpc_pkg::ST_CHECK;
            tpc_pkg::ST_CHECK:
                state_next = tpc_pkg::ST_DIVIDE;
            tpc_pkg::ST_DIVIDE:
                if (status.div_done)
                begin
                    state_next = tpc_pkg::ST_FINISH;
                end
            tpc_pkg::ST_FINISH:
                if (status.out_free)
                begin
                    state_next = tpc_pkg::ST_IDLE;
                end
            default:
                state_next = tpc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            tpc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            tpc_pkg::ST_UPDATE:
                cmd.update = 1'b1;
            tpc_pkg::ST_BOUND:
                cmd.bound = 1'b1;
            tpc_pkg::ST_CHECK:
                cmd.check = 1'b1;
            tpc_pkg::ST_DIVIDE:
                cmd = '0;
            tpc_pkg::ST_FINISH:
                cmd.finish = status.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/tpc_datapath.sv -----
// ----------------------------------------------------------------------------
// tpc datapath
// Deadzone, sample ring with running sums, window test, averaging dividers
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpc_datapath #(
    parameter int FILTER_DEPTH = tpc_pkg::DEFAULT_FILTER_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpc_pkg::tpc_cmd_t    cmd,
    output tpc_pkg::tpc_status_t status,
    input  tpc_pkg::tpc_cfg_t    cfg,
    input  tpc_pkg::tpc_in_t     in_item,
    input  logic                 out_stall,
    output logic                 out_valid,
    output tpc_pkg::tpc_out_t    out_item
);

    localparam int COORD_W = tpc_pkg::COORD_W;
    localparam int SLOT_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FILTER_DEPTH + 1);
    localparam int SUM_W   = COORD_W + $clog2(FILTER_DEPTH);
    localparam int PROD_W  = COORD_W + CNT_W;
    localparam int DIV_W   = SUM_W + tpc_pkg::FRAC_W;

    // sample ring, x in the upper half of each entry
    logic [2*COORD_W-1:0] ring_mem [FILTER_DEPTH];
    logic [2*COORD_W-1:0] rd_reg;

    tpc_pkg::tpc_in_t     raw_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic                 ring_full_reg;
    logic                 ring_full_next;
    logic [SUM_W-1:0]     sum_x_reg;
    logic [SUM_W-1:0]     sum_y_reg;
    logic [COORD_W-1:0]   last_x_reg;
    logic [COORD_W-1:0]   last_y_reg;
    logic [tpc_pkg::TIME_W-1:0] last_seen_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [PROD_W-1:0]    lo_x_reg;
    logic [PROD_W-1:0]    hi_x_reg;
    logic [PROD_W-1:0]    lo_y_reg;
    logic [PROD_W-1:0]    hi_y_reg;
    logic                 inside_reg;
    logic                 home_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tpc_pkg::tpc_out_t    out_item_reg;

    logic [COORD_W-1:0]   diff_x;
    logic [COORD_W-1:0]   diff_y;
    logic [COORD_W-1:0]   x_dz;
    logic [COORD_W-1:0]   y_dz;
    logic [COORD_W-1:0]   old_x;
    logic [COORD_W-1:0]   old_y;
    logic [PROD_W-1:0]    sum_x_ext;
    logic [PROD_W-1:0]    sum_y_ext;
    logic [tpc_pkg::TIME_W-1:0] elapsed;
    logic                 in_area;
    logic                 home;
    logic [DIV_W-1:0]     quo_x;
    logic [DIV_W-1:0]     quo_y;
    logic                 div_done_x;
    logic                 div_done_y;

    // deadzone against the last accepted coordinate
    assign diff_x = (raw_reg.x_raw >= last_x_reg) ? raw_reg.x_raw - last_x_reg
                                                  : last_x_reg - raw_reg.x_raw;
    assign diff_y = (raw_reg.y_raw >= last_y_reg) ? raw_reg.y_raw - last_y_reg
                                                  : last_y_reg - raw_reg.y_raw;
    assign x_dz   = (diff_x < cfg.deadzone) ? last_x_reg : raw_reg.x_raw;
    assign y_dz   = (diff_y < cfg.deadzone) ? last_y_reg : raw_reg.y_raw;

    // slots not yet written since reset count as zero
    assign old_x = ring_full_reg ? rd_reg[2*COORD_W-1:COORD_W] : '0;
    assign old_y = ring_full_reg ? rd_reg[COORD_W-1:0] : '0;

    always_comb
    begin
        slot_next      = slot_reg + 1'b1;
        ring_full_next = ring_full_reg;
        if (slot_reg == SLOT_W'(FILTER_DEPTH - 1))
        begin
            slot_next      = '0;
            ring_full_next = 1'b1;
        end
    end

    assign count_next = ring_full_reg ? CNT_W'(FILTER_DEPTH) : CNT_W'(slot_reg);

    assign sum_x_ext = PROD_W'(sum_x_reg);
    assign sum_y_ext = PROD_W'(sum_y_reg);
    assign elapsed   = raw_reg.time_ms - last_seen_reg;

    assign in_area = raw_reg.pressed && (count_reg != '0)
                  && (sum_x_ext >= lo_x_reg) && (sum_x_ext <= hi_x_reg)
                  && (sum_y_ext >= lo_y_reg) && (sum_y_ext <= hi_y_reg);
    assign home    = !in_area && (elapsed >= tpc_pkg::TIME_W'(cfg.lost_timeout_ms));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg <= ring_mem[slot_reg];
        end
        if (cmd.update && raw_reg.pressed)
        begin
            ring_mem[slot_reg] <= {x_dz, y_dz};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            ring_full_reg <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            last_seen_reg <= '0;
        end
        else
        begin
            if (cmd.update && raw_reg.pressed)
            begin
                sum_x_reg     <= sum_x_reg - SUM_W'(old_x) + SUM_W'(x_dz);
                sum_y_reg     <= sum_y_reg - SUM_W'(old_y) + SUM_W'(y_dz);
                slot_reg      <= slot_next;
                ring_full_reg <= ring_full_next;
                last_x_reg    <= x_dz;
                last_y_reg    <= y_dz;
            end
            if (cmd.check && in_area)
            begin
                last_seen_reg <= raw_reg.time_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= in_item;
        end
        if (cmd.bound)
        begin
            count_reg <= count_next;
            lo_x_reg  <= PROD_W'(cfg.window_min_x) * PROD_W'(count_next);
            hi_x_reg  <= PROD_W'(cfg.window_max_x) * PROD_W'(count_next);
            lo_y_reg  <= PROD_W'(cfg.window_min_y) * PROD_W'(count_next);
            hi_y_reg  <= PROD_W'(cfg.window_max_y) * PROD_W'(count_next);
        end
        if (cmd.check)
        begin
            inside_reg <= in_area;
            home_reg   <= home;
        end
        if (cmd.finish)
        begin
            out_item_reg.avg_x     <= (count_reg == '0) ? '0 : quo_x[tpc_pkg::AVG_W-1:0];
            out_item_reg.avg_y     <= (count_reg == '0) ? '0 : quo_y[tpc_pkg::AVG_W-1:0];
            out_item_reg.in_window <= inside_reg;
            out_item_reg.go_home   <= home_reg;
        end
    end

    tpc_serial_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.bound),
        .dividend ({sum_x_reg, {tpc_pkg::FRAC_W{1'b0}}}),
        .divisor  (count_next),
        .quotient (quo_x),
        .done     (div_done_x)
    );

    tpc_serial_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (CNT_W)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.bound),
        .dividend ({sum_y_reg, {tpc_pkg::FRAC_W{1'b0}}}),
        .divisor  (count_next),
        .quotient (quo_y),
        .done     (div_done_y)
    );

    // result register frees the controller while a result waits
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.div_done = div_done_x && div_done_y;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a waiting result");

    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bound |-> (div_done_x && div_done_y))
        else $error("division started while busy");

    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        ring_full_reg |=> ring_full_reg)
        else $error("ring full flag dropped");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.in_window && out_item_reg.go_home))
        else $error("in_window and go_home both set");

    a_inside_needs_samples: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.in_window) |-> (ring_full_reg || slot_reg != '0))
        else $error("in_window with an empty ring");

endmodule

// ----- sv/touch_point_conditioner_core.sv -----
// ----------------------------------------------------------------------------
// touch point conditioner core
// Deadzone and moving average over touch samples with window and lost test.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  tpc_in_t  (x_raw y_raw pressed time_ms)
//   out       output     out_valid/out_stall  tpc_out_t (avg_x avg_y in_window go_home)
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// a new item is taken only once the previous one has left the finish step
// the bit-serial averaging dividers start in the bound step; divide waits until both are done
// a finished result waits in the output register while the next item is taken
// a result still waiting when the next one is finished holds that item back
// reset clears the ring fill state, sums and flags at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_point_conditioner_core #(
    parameter int FILTER_DEPTH = tpc_pkg::DEFAULT_FILTER_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tpc_pkg::tpc_in_t               in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tpc_pkg::tpc_out_t              out_item,
    input  logic                           cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    tpc_pkg::tpc_cfg_t    cfg;
    tpc_pkg::tpc_cmd_t    cmd;
    tpc_pkg::tpc_status_t status;

    tpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tpc_datapath #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .in_item   (in_item),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
